FILE: hw/rtl/wcpd_pkg.sv
package wcpd_pkg;

	localparam int LANES = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_COLUMNS = 16000;
	localparam int COL_BITS = 14;
	localparam int LEN_BITS = 32;
	localparam int CH_BITS = 3;
	localparam int SUM_BITS = 64;
	localparam int CNT_BITS = 34;
	localparam int SQ_BITS = 2 * SAMPLE_BITS;
	// lane merge adds at most LANES squares
	localparam int LSUM_BITS = SQ_BITS + 2;

	localparam logic [1:0] REG_RANGE_LENGTH = 2'd0;
	localparam logic [1:0] REG_NUM_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ACTIVE_CHANNELS = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic    en;
		sample_t v;
		logic [SQ_BITS-1:0] sq;
	} lane_res_t;

	typedef struct packed {
		sample_t mn;
		sample_t mx;
		logic [LSUM_BITS-1:0] sq;
		logic [2:0] cnt;
	} frame_sum_t;

	typedef struct packed {
		sample_t mn;
		sample_t mx;
		logic [SAMPLE_BITS-1:0] rms;
		logic [COL_BITS-1:0] rep;
		logic done;
		logic last;
	} result_t;

endpackage

FILE: hw/rtl/wcpd_lane.sv
// One channel: gate by the lane count and square the magnitude.
module wcpd_lane (
	input  logic                clk,
	input  logic                load,
	input  logic                en,
	input  wcpd_pkg::sample_t   sample,
	output wcpd_pkg::lane_res_t res
);
	logic [wcpd_pkg::SAMPLE_BITS-1:0] mag;
	assign mag = sample[wcpd_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

	always_ff @(posedge clk) begin
		if (load) begin
			res.en <= en;
			res.v  <= sample;
			res.sq <= mag * mag;
		end
	end
endmodule

FILE: hw/rtl/wcpd_merge.sv
// Combine lane results of one frame into min, max, square sum and count.
module wcpd_merge (
	input  wcpd_pkg::lane_res_t  lanes [wcpd_pkg::LANES],
	output wcpd_pkg::frame_sum_t fs
);
	always_comb begin
		fs.mn = lanes[0].v;
		fs.mx = lanes[0].v;
		fs.sq = '0;
		fs.cnt = '0;
		for (int i = 0; i < wcpd_pkg::LANES; i++) begin
			if (lanes[i].en) begin
				if (lanes[i].v < fs.mn) fs.mn = lanes[i].v;
				if (lanes[i].v > fs.mx) fs.mx = lanes[i].v;
				fs.sq = fs.sq + wcpd_pkg::LSUM_BITS'(lanes[i].sq);
				fs.cnt = fs.cnt + 3'd1;
			end
		end
	end
endmodule

FILE: hw/rtl/wcpd_divsqrt.sv
// Restoring divide (one quotient bit per cycle) then bit-pair square root.
module wcpd_divsqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [wcpd_pkg::SUM_BITS-1:0]      num,
	input  logic [wcpd_pkg::CNT_BITS-1:0]      den,
	output logic                               busy,
	output logic [wcpd_pkg::SAMPLE_BITS-1:0]   root
);
	localparam int W = wcpd_pkg::SUM_BITS;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;

	logic [1:0] st_q;
	logic [6:0] cnt_q;
	logic [W-1:0] quo_q;
	logic [W:0] rem_q;
	logic [wcpd_pkg::CNT_BITS-1:0] den_q;
	logic [W-1:0] sv_q;
	logic [W-1:0] rt_q;
	logic [W-1:0] bit_q;
	logic [W:0] rem_sh;
	logic [W-1:0] trial;

	assign busy = (st_q != ST_IDLE) || start;
	assign root = wcpd_pkg::SAMPLE_BITS'(rt_q);
	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign trial = rt_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (start) begin
					st_q <= ST_DIV;
					cnt_q <= 7'(W);
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= ST_SQRT;
						cnt_q <= 7'(W / 2);
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (st_q == ST_DIV) begin
			if (rem_sh >= (W+1)'(den_q)) begin
				rem_q <= rem_sh - (W+1)'(den_q);
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
			if (cnt_q == 7'd1) begin
				sv_q <= {quo_q[W-2:0], (rem_sh >= (W+1)'(den_q))};
				rt_q <= '0;
				bit_q <= W'(1) << (W - 2);
			end
		end else if (st_q == ST_SQRT) begin
			if (sv_q >= trial) begin
				sv_q <= sv_q - trial;
				rt_q <= (rt_q >> 1) + bit_q;
			end else begin
				rt_q <= rt_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

FILE: hw/rtl/waveform_column_peak_decimator.sv
// Min/max/RMS column decimator. Every accepted frame runs the 48-bit serial
// divide that finds the frame's target column. A frame that only opens an
// empty run also passes through the empty-run state. Closing a filled column
// adds a 64-bit restoring divide and a square root, and the window's last frame
// runs the same unit again for the final column, also when it closes a filled
// column. Output stalls can hold the block where it waits to queue a result.
// Four sample lanes square in parallel and a merge stage folds them into the
// column's running statistics. A write to one of the three configuration
// registers restarts the window.
module waveform_column_peak_decimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // sample_0, sample_1, sample_2, sample_3
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // column_min, column_max, column_rms, repeat_count
	output logic        m_tlast,  // last_of_run
	output logic        m_tuser,  // window_done
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int CB = wcpd_pkg::COL_BITS;
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LANE = 4'd1;
	localparam logic [3:0] ST_MUL = 4'd2;
	localparam logic [3:0] ST_TGT = 4'd3;
	localparam logic [3:0] ST_CLOSE = 4'd4;
	localparam logic [3:0] ST_WAITC = 4'd5;
	localparam logic [3:0] ST_EMPTY = 4'd6;
	localparam logic [3:0] ST_ACC = 4'd7;
	localparam logic [3:0] ST_WAITF = 4'd8;
	localparam logic [3:0] ST_DIVW = 4'd9;
	localparam logic [3:0] ST_DRAIN = 4'd10;

	logic [31:0] len_q;
	logic [CB-1:0] cols_q;
	logic [2:0] ach_q;
	logic [3:0] st_q;
	logic [31:0] fidx_q;
	logic [CB-1:0] cur_q;
	logic has_q;
	wcpd_pkg::sample_t mn_q, mx_q;
	logic [63:0] sum_q;
	logic [33:0] cnt_q;
	logic [63:0] samp_q;
	logic [47:0] prod_q;
	logic [CB-1:0] tgt_q;
	logic [31:0] len_e;
	logic [CB-1:0] cols_e;
	logic [2:0] lanes_e;
	wcpd_pkg::lane_res_t lres [wcpd_pkg::LANES];
	wcpd_pkg::frame_sum_t fs;
	logic ds_start, ds_busy;
	logic [15:0] ds_root;
	logic [63:0] ds_num;
	logic [33:0] ds_den;
	logic [1:0] qv_q;
	logic [1:0] qv_n;
	wcpd_pkg::result_t q_q [2];
	wcpd_pkg::result_t q_n [2];
	logic pend_q;
	logic pend_mv;
	wcpd_pkg::result_t pend_r_q;
	logic pop;
	logic is_last;
	logic [47:0] tnum;
	logic [47:0] tq;
	logic [47:0] tq_m1;
	logic [CB-1:0] tgt_c;
	logic adv_c;

	assign len_e = (len_q == '0) ? 32'd1 : len_q;
	assign cols_e = (cols_q == '0) ? CB'(1) :
		(cols_q > CB'(wcpd_pkg::MAX_COLUMNS)) ? CB'(wcpd_pkg::MAX_COLUMNS) : cols_q;
	assign lanes_e = (ach_q == '0) ? 3'd1 : (ach_q > 3'd4) ? 3'd4 : ach_q;
	assign is_last = (33'(fidx_q) + 33'd1) >= 33'(len_e);
	assign s_tready = (st_q == ST_IDLE) && !cfg_we;

	for (genvar i = 0; i < wcpd_pkg::LANES; i++) begin : g_lane
		wcpd_lane u_lane (
			.clk(clk), .load(st_q == ST_LANE), .en(3'(i) < lanes_e),
			.sample(samp_q[16*i +: 16]), .res(lres[i])
		);
	end

	wcpd_merge u_merge (.lanes(lres), .fs(fs));

	wcpd_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .start(ds_start), .num(ds_num), .den(ds_den),
		.busy(ds_busy), .root(ds_root)
	);

	// target column numerator; divide by len via the shared long divider is
	// too slow per frame, so do a 48-bit restoring divide serially instead
	logic [5:0] tdc_q;
	logic [48:0] trem_q;
	logic [47:0] tquo_q;
	logic [48:0] trem_sh;
	assign trem_sh = {trem_q[47:0], tquo_q[47]};
	assign tnum = prod_q + 48'(len_e) - 48'd1;
	assign tq = tquo_q;

	assign ds_num = sum_q;
	assign ds_den = cnt_q;
	assign pop = m_tvalid && m_tready;

	// tq is the final quotient in ST_CLOSE
	always_comb begin
		tq_m1 = tq - 48'd1;
		if (tq == '0) tgt_c = cur_q;
		else if (tq_m1 > 48'(cols_e) - 48'd1) tgt_c = cols_e - CB'(1);
		else if (CB'(tq_m1) < cur_q) tgt_c = cur_q;
		else tgt_c = CB'(tq_m1);
		adv_c = tgt_c > cur_q;
	end

	always_comb begin
		ds_start = 1'b0;
		unique case (st_q)
			ST_CLOSE: ds_start = has_q && adv_c;
			// start the final-column root
			ST_WAITF: ds_start = 1'b1;
			default: ;
		endcase
	end

	// output queue: two slots, slot 0 is the head
	always_comb begin
		q_n = q_q;
		qv_n = qv_q;
		if (pop) begin
			q_n[0] = q_q[1];
			qv_n = {1'b0, qv_q[1]};
		end
		pend_mv = pend_q && !qv_n[1];
		if (pend_mv) begin
			if (!qv_n[0]) begin
				q_n[0] = pend_r_q;
				qv_n[0] = 1'b1;
			end else begin
				q_n[1] = pend_r_q;
				qv_n[1] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 32'd1;
			cols_q <= CB'(1);
			ach_q <= 3'd1;
			st_q <= ST_IDLE;
			fidx_q <= '0;
			cur_q <= '0;
			has_q <= 1'b0;
			mn_q <= '0;
			mx_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			qv_q <= '0;
			pend_q <= 1'b0;
			tdc_q <= '0;
		end else begin
			qv_q <= qv_n;
			if (pend_mv) pend_q <= 1'b0;
			if (cfg_we && cfg_index <= wcpd_pkg::REG_ACTIVE_CHANNELS) begin
				unique case (cfg_index)
					wcpd_pkg::REG_RANGE_LENGTH: len_q <= cfg_data;
					wcpd_pkg::REG_NUM_COLUMNS: cols_q <= cfg_data[CB-1:0];
					default: ach_q <= cfg_data[2:0];
				endcase
				fidx_q <= '0;
				cur_q <= '0;
				has_q <= 1'b0;
				mn_q <= '0;
				mx_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				unique case (st_q)
					ST_IDLE: if (s_tvalid) begin
						samp_q <= s_tdata;
						st_q <= ST_LANE;
					end
					ST_LANE: begin
						prod_q <= (48'(fidx_q) + 48'd1) * 48'(cols_e);
						st_q <= ST_MUL;
					end
					ST_MUL: begin
						tquo_q <= tnum;
						trem_q <= '0;
						tdc_q <= 6'd48;
						st_q <= ST_TGT;
					end
					ST_TGT: begin
						if (trem_sh >= 49'(len_e)) begin
							trem_q <= trem_sh - 49'(len_e);
							tquo_q <= {tquo_q[46:0], 1'b1};
						end else begin
							trem_q <= trem_sh;
							tquo_q <= {tquo_q[46:0], 1'b0};
						end
						tdc_q <= tdc_q - 6'd1;
						if (tdc_q == 6'd1) st_q <= ST_CLOSE;
					end
					ST_CLOSE: begin
						tgt_q <= tgt_c;
						if (adv_c) begin
							st_q <= has_q ? ST_WAITC : ST_EMPTY;
						end else begin
							st_q <= ST_ACC;
						end
					end
					ST_WAITC: if (!ds_busy && !pend_q) begin
						// closed filled column ends the run only when no empty run
						// and no window end follow
						pend_q <= 1'b1;
						pend_r_q <= '{mn: mn_q, mx: mx_q, rms: ds_root, rep: CB'(1),
							done: 1'b0, last: (tgt_q == cur_q + CB'(1)) && !is_last};
						cur_q <= cur_q + CB'(1);
						has_q <= 1'b0;
						st_q <= ST_EMPTY;
					end
					ST_EMPTY: if (!pend_q) begin
						if (tgt_q > cur_q) begin
							pend_q <= 1'b1;
							pend_r_q <= '{mn: '0, mx: '0, rms: '0, rep: tgt_q - cur_q,
								done: 1'b0, last: !is_last};
						end
						cur_q <= tgt_q;
						has_q <= 1'b0;
						mn_q <= '0;
						mx_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
						st_q <= ST_ACC;
					end
					ST_ACC: begin
						if (!has_q) begin
							mn_q <= fs.mn;
							mx_q <= fs.mx;
						end else begin
							if (fs.mn < mn_q) mn_q <= fs.mn;
							if (fs.mx > mx_q) mx_q <= fs.mx;
						end
						has_q <= 1'b1;
						sum_q <= sum_q + 64'(fs.sq);
						cnt_q <= cnt_q + 34'(fs.cnt);
						if (is_last) begin
							st_q <= ST_WAITF;
						end else begin
							fidx_q <= fidx_q + 32'd1;
							st_q <= ST_IDLE;
						end
					end
					ST_WAITF: st_q <= ST_DIVW;
					ST_DIVW: if (!ds_busy && !pend_q) begin
						pend_q <= 1'b1;
						pend_r_q <= '{mn: mn_q, mx: mx_q, rms: ds_root, rep: CB'(1),
							done: 1'b1, last: 1'b1};
						fidx_q <= '0;
						cur_q <= '0;
						has_q <= 1'b0;
						mn_q <= '0;
						mx_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
						st_q <= ST_DRAIN;
					end
					ST_DRAIN: if (!pend_q) st_q <= ST_IDLE;
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign m_tvalid = qv_q[0];
	assign m_tdata = {2'b00, q_q[0].rep, q_q[0].rms, q_q[0].mx, q_q[0].mn};
	assign m_tlast = q_q[0].last;
	assign m_tuser = q_q[0].done;
endmodule

FILE: hw/rtl/wcpd_checker.sv
module wcpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser,
	input logic        cfg_we
);
	// a window-done result always ends a frame's run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("done without last");
	// repeat count is never zero
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[61:48] != 14'd0) else $error("zero repeat");
	// no input taken during a config write
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !s_tready) else $error("accept during config");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("drop");
endmodule

bind waveform_column_peak_decimator wcpd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tlast(m_tlast), .m_tuser(m_tuser), .cfg_we(cfg_we)
);

FILE: tb/waveform_column_peak_decimator_tb.sv
`timescale 1ns / 1ps

module waveform_column_peak_decimator_tb;

	localparam int IDLE_CYCLES = 200;
	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	waveform_column_peak_decimator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the block's registers and column accumulator
	logic [31:0] sh_len = 32'd1;
	logic [13:0] sh_cols = 14'd1;
	logic [2:0]  sh_ch = 3'd1;
	logic [31:0] frame_idx = '0;
	logic [13:0] cur_col = '0;
	logic        col_filled = 1'b0;
	int          col_min = 0;
	int          col_max = 0;
	logic [63:0] sq_sum = '0;
	logic [63:0] smp_cnt = '0;

	logic [63:0] frame_q[$];
	wcpd_pkg::result_t column_q[$];

	int errors = 0;
	int frames_sent = 0;
	int columns_seen = 0;
	int windows_seen = 0;
	int phases = 0;
	int quiet_cycles = 0;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic void clear_column();
		col_filled = 1'b0;
		col_min = 0;
		col_max = 0;
		sq_sum = 0;
		smp_cnt = 0;
	endfunction

	function automatic void push_column(input int mn, input int mx, input logic [63:0] rms,
			input logic [13:0] rep, input logic done);
		wcpd_pkg::result_t r;
		r.mn = mn[15:0];
		r.mx = mx[15:0];
		r.rms = rms[15:0];
		r.rep = rep;
		r.done = done;
		r.last = 1'b0;
		column_q.push_back(r);
	endfunction

	function automatic void push_current(input logic done);
		logic [63:0] rms;
		rms = (smp_cnt != 0) ? floor_sqrt(sq_sum / smp_cnt) : 64'd0;
		push_column(col_min, col_max, rms, 14'd1, done);
	endfunction

	function automatic void restart_window();
		frame_idx = 0;
		cur_col = 0;
		clear_column();
	endfunction

	function automatic void apply_cfg(input logic [1:0] idx, input logic [31:0] val);
		case (idx)
			wcpd_pkg::REG_RANGE_LENGTH: sh_len = val;
			wcpd_pkg::REG_NUM_COLUMNS: sh_cols = val[13:0];
			wcpd_pkg::REG_ACTIVE_CHANNELS: sh_ch = val[2:0];
			default: return;
		endcase
		restart_window();
	endfunction

	function automatic void predict_frame(input logic [63:0] d);
		logic [63:0] len;
		logic [63:0] cols;
		logic [63:0] tgt;
		int lanes;
		logic [13:0] c;
		logic [13:0] run_start;
		int n;
		int v;
		logic [63:0] mag;
		len = (sh_len != 0) ? {32'd0, sh_len} : 64'd1;
		cols = (sh_cols != 0) ? {50'd0, sh_cols} : 64'd1;
		if (cols > wcpd_pkg::MAX_COLUMNS)
			cols = wcpd_pkg::MAX_COLUMNS;
		lanes = (sh_ch != 0) ? sh_ch : 1;
		if (lanes > wcpd_pkg::LANES)
			lanes = wcpd_pkg::LANES;
		n = column_q.size();
		tgt = (({32'd0, frame_idx} + 64'd1) * cols + len - 64'd1) / len;
		tgt = (tgt != 0) ? tgt - 1 : 0;
		if (tgt > cols - 1)
			tgt = cols - 1;
		c = tgt[13:0];
		// never step back to an earlier column
		if (c < cur_col)
			c = cur_col;
		if (c > cur_col) begin
			run_start = cur_col;
			if (col_filled) begin
				push_current(1'b0);
				run_start++;
			end
			if (c > run_start)
				push_column(0, 0, 64'd0, c - run_start, 1'b0);
			cur_col = c;
			clear_column();
		end
		for (int ch = 0; ch < lanes; ch++) begin
			v = $signed(d[16*ch +: 16]);
			mag = (v < 0) ? -v : v;
			if (!col_filled) begin
				col_min = v;
				col_max = v;
				col_filled = 1'b1;
			end else begin
				if (v < col_min) col_min = v;
				if (v > col_max) col_max = v;
			end
			sq_sum += mag * mag;
			smp_cnt++;
		end
		if ({32'd0, frame_idx} + 64'd1 >= len) begin
			push_current(1'b1);
			restart_window();
		end else begin
			frame_idx++;
		end
		if (column_q.size() > n)
			column_q[column_q.size()-1].last = 1'b1;
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		logic nv;
		logic [63:0] nd;
		nv = s_tvalid;
		nd = s_tdata;
		if (s_tvalid && s_tready) begin
			predict_frame(s_tdata);
			frames_sent++;
			nv = 1'b0;
		end
		if (!nv && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (frame_q.size() != 0) begin
				nd = frame_q.pop_front();
				nv = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
				end
			end
		end
		s_tvalid <= nv;
		s_tdata <= nd;
	end

	// receiver: stall pattern drifts between modes
	int rx_cyc = 0;
	always @(posedge clk) begin
		wcpd_pkg::result_t exp_r;
		logic rdy;
		rx_cyc++;
		if (m_tvalid && m_tready) begin
			columns_seen++;
			if (column_q.size() == 0) begin
				$error("unexpected column result data=%h", m_tdata);
				errors++;
			end else begin
				exp_r = column_q.pop_front();
				if (m_tdata[15:0] !== exp_r.mn) begin
					$error("column_min exp %0d got %0d", exp_r.mn, $signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[31:16] !== exp_r.mx) begin
					$error("column_max exp %0d got %0d", exp_r.mx, $signed(m_tdata[31:16]));
					errors++;
				end
				if (m_tdata[47:32] !== exp_r.rms) begin
					$error("column_rms exp %0d got %0d", exp_r.rms, m_tdata[47:32]);
					errors++;
				end
				if (m_tdata[61:48] !== exp_r.rep) begin
					$error("repeat_count exp %0d got %0d", exp_r.rep, m_tdata[61:48]);
					errors++;
				end
				if (m_tuser !== exp_r.done) begin
					$error("window_done exp %0b got %0b", exp_r.done, m_tuser);
					errors++;
				end
				else if (exp_r.done)
					windows_seen++;
				if (m_tlast !== exp_r.last) begin
					$error("last_of_run exp %0b got %0b", exp_r.last, m_tlast);
					errors++;
				end
			end
		end
		case (rx_cyc[9:8])
			2'd0: rdy = 1'b1;
			2'd1: rdy = 1'($urandom_range(0, 1));
			2'd2: rdy = ($urandom_range(0, 7) == 0);
			default: rdy = (rx_cyc[3:0] < 4'd10);
		endcase
		m_tready <= rdy && arst_n;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d frames pending, %0d columns awaited",
				frame_q.size(), column_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_cfg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (frame_q.size() != 0 || s_tvalid || column_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic setup(input logic [31:0] len, input logic [31:0] cols, input logic [31:0] ch);
		write_reg(wcpd_pkg::REG_RANGE_LENGTH, len);
		write_reg(wcpd_pkg::REG_NUM_COLUMNS, cols);
		write_reg(wcpd_pkg::REG_ACTIVE_CHANNELS, ch);
		phases++;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic void queue_random(input int count);
		logic [63:0] d;
		for (int i = 0; i < count; i++) begin
			for (int ch = 0; ch < 4; ch++)
				d[16*ch +: 16] = pick_sample();
			frame_q.push_back(d);
		end
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: every frame is its own window
		frame_q.push_back({16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000});
		frame_q.push_back({4{16'h7FFF}});
		frame_q.push_back({4{16'h8000}});
		frame_q.push_back(64'd0);
		drain();

		// full lanes, mixed extremes in one column
		setup(32'd4, 32'd2, 32'd4);
		frame_q.push_back({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
		frame_q.push_back({16'h7FFF, 16'h8000, 16'h1234, 16'h8001});
		frame_q.push_back({4{16'h8000}});
		frame_q.push_back({4{16'h7FFF}});
		drain();

		// more columns than frames: empty runs between filled ones
		setup(32'd3, 32'd11, 32'd2);
		queue_random(6);
		drain();

		// zero registers act as one, wide channel count saturates
		setup(32'd0, 32'd0, 32'd0);
		queue_random(2);
		drain();
		setup(32'd2, 32'h3FFF, 32'd7);
		queue_random(4);
		drain();

		// longest window: no column ever closes
		setup(32'hFFFF_FFFF, 32'd16000, 32'd3);
		queue_random(3);
		drain();

		// unused index leaves the open window alone
		setup(32'd5, 32'd2, 32'd1);
		queue_random(2);
		drain();
		write_reg(2'd3, $urandom());
		queue_random(3);
		drain();

		while (frames_sent < 290) begin
			logic [31:0] len;
			logic [31:0] cols;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
			cols = ($urandom_range(0, 9) == 0) ? $urandom_range(16000, 16383)
				: $urandom_range(0, 30);
			setup(len, cols, $urandom_range(0, 7));
			queue_random($urandom_range(5, 40));
			drain();
		end

		$display("covered %0d frames over %0d register settings", frames_sent, phases);
		$display("checked %0d column results, %0d window ends", columns_seen, windows_seen);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/wcpd_pkg.sv
hw/rtl/wcpd_lane.sv
hw/rtl/wcpd_merge.sv
hw/rtl/wcpd_divsqrt.sv
hw/rtl/waveform_column_peak_decimator.sv
hw/rtl/wcpd_checker.sv
tb/waveform_column_peak_decimator_tb.sv
